### hdl/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the source token lexer: token kinds, character
// codes, the keyword table and the token bundle passed from front to back.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int KIND_BITS       = 5;
   localparam int OFFSET_OUT_BITS = 32;
   localparam int POS_OUT_BITS    = 16;
   localparam int LENGTH_BITS     = 16;

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_ADD     = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_LT      = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_GT      = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_SUB     = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_MUL     = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_DIV     = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_SPACE   = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_INT     = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_KW_BASE = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_ERROR   = 5'd20;

   // character codes
   localparam logic [7:0] CHAR_BOM0   = 8'hEF;
   localparam logic [7:0] CHAR_BOM1   = 8'hBB;
   localparam logic [7:0] CHAR_BOM2   = 8'hBF;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   // keyword table, kinds follow KIND_KW_BASE in this order
   localparam int KW_COUNT     = 8;
   localparam int KW_MAX_CHARS = 6;
   localparam int KW_LEN [KW_COUNT] = '{6, 2, 2, 3, 5, 6, 3, 4};
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_CHARS] = '{
      '{"r", "e", "t", "u", "r", "n"},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "n", "d", 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"b", "u", "f", "f", "e", "r"},
      '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
      '{"a", "u", "t", "o", 8'h00, 8'h00}
   };

   // bundle slots, delivered lowest first
   localparam int TOKEN_SLOTS  = 4;
   localparam int SLOT_REPLAY0 = 0;
   localparam int SLOT_REPLAY1 = 1;
   localparam int SLOT_FLUSH   = 2;
   localparam int SLOT_LAST    = 3;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [KIND_BITS-1:0]       kind;
      logic [OFFSET_OUT_BITS-1:0] start_offset;
      logic [LENGTH_BITS-1:0]     token_length;
      logic [POS_OUT_BITS-1:0]    start_line;
      logic [POS_OUT_BITS-1:0]    start_column;
      logic [POS_OUT_BITS-1:0]    end_line;
      logic [POS_OUT_BITS-1:0]    end_column;
   } token_type;

   typedef struct packed {
      token_type [TOKEN_SLOTS-1:0] tokens;
      logic [TOKEN_SLOTS-1:0]      valid;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### hdl/stl_interfaces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_interfaces
// Valid/ready channels of the source token lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface stl_rsp_if import stl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [KIND_BITS-1:0]       token_kind;
   logic [OFFSET_OUT_BITS-1:0] start_offset;
   logic [LENGTH_BITS-1:0]     token_length;
   logic [POS_OUT_BITS-1:0]    start_line;
   logic [POS_OUT_BITS-1:0]    start_column;
   logic [POS_OUT_BITS-1:0]    end_line;
   logic [POS_OUT_BITS-1:0]    end_column;
   logic                       last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output start_line, output start_column,
                   output end_line, output end_column, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input token_length, input start_line, input start_column,
                 input end_line, input end_column, input last_of_run,
                 output ready);
endinterface

### hdl/source_token_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer_top
// Streaming lexer: source bytes in, positioned tokens out.
// ----------------------------------------------------------------------------
// req_channel takes one source byte per transfer, or an end marker that
// flushes the pending token, sends an eof token and rearms for a new file.
// rsp_channel gives one token per transfer; last_of_run marks the final token
// caused by a given input transfer (a byte may cause none, up to three).
// csr_write_data sets the whitespace-token enable while csr_write_enable is
// high; write it only while the block is idle.
// Throughput: one byte per cycle while the queue is not full, set by the
// scanner update in the front end; the token port gives one token per cycle
// while rsp_channel.ready is high, so a byte holds the back end until its
// last token goes. A token's bundle waits in the queue, then the back end.
// Stall: the front end writes bundles into a two-entry queue and the back end
// holds one more; req_channel.ready drops only when the queue is full.
// Reset (synchronous): scanner back to the file-start prologue, positions at
// zero, whitespace tokens disabled, queue and output empty.
// ----------------------------------------------------------------------------
module source_token_lexer_top import stl_pkg::*; #(
   parameter int KEYWORD_MAX_LEN = 6,
   parameter int POSITION_BITS   = 16,
   parameter int OFFSET_BITS     = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   stl_req_if.sink   req_channel,
   stl_rsp_if.source rsp_channel
);

   queue_status_type status;
   logic             push, pop;
   bundle_type       push_data, pop_data;

   stl_front #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .POSITION_BITS   (POSITION_BITS),
      .OFFSET_BITS     (OFFSET_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_channel),
      .status           (status),
      .push             (push),
      .push_data        (push_data)
   );

   stl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   stl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_data    (pop_data),
      .status      (status),
      .pop         (pop),
      .rsp_channel (rsp_channel)
   );

endmodule

### hdl/stl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front
// Scanner front end: takes one source byte per transfer, normalises line
// endings, runs the prologue and token state, and writes the tokens caused by
// the byte into the queue as one bundle.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; #(
   parameter int KEYWORD_MAX_LEN = 6,
   parameter int POSITION_BITS   = 16,
   parameter int OFFSET_BITS     = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   stl_req_if.sink          req_channel,
   input  queue_status_type status,
   output logic             push,
   output bundle_type       push_data
);

   localparam int PREFIX_IDX_BITS = $clog2(KEYWORD_MAX_LEN);

   typedef enum logic [9:0] {
      MODE_BOM0       = 10'b0000000001,
      MODE_BOM1       = 10'b0000000010,
      MODE_BOM2       = 10'b0000000100,
      MODE_LINE_START = 10'b0000001000,
      MODE_HASH       = 10'b0000010000,
      MODE_SKIP       = 10'b0000100000,
      MODE_IDLE       = 10'b0001000000,
      MODE_WS         = 10'b0010000000,
      MODE_INT        = 10'b0100000000,
      MODE_IDENT      = 10'b1000000000
   } mode_type;

   mode_type                 mode_ff, mode_in, norm_mode;
   logic                     emit_ws_ff;
   logic                     cr_ff, cr_in;
   logic [OFFSET_BITS-1:0]   pos_ff, pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [OFFSET_BITS-1:0]   pend_off_ff, pend_off_in;
   logic [POSITION_BITS-1:0] pend_line_ff, pend_line_in;
   logic [POSITION_BITS-1:0] pend_col_ff, pend_col_in;
   logic [LENGTH_BITS-1:0]   pend_len_ff, pend_len_in;
   logic [7:0]               prefix_ff [KEYWORD_MAX_LEN];
   logic [7:0]               prefix_in [KEYWORD_MAX_LEN];

   logic                     accept, drop, do_normal;
   logic [1:0]               rep_n;
   logic [7:0]               raw_byte, byte_norm;
   logic                     is_ws, is_digit, is_alpha, op_valid;
   logic [KIND_BITS-1:0]     op_kind;
   logic [OFFSET_BITS-1:0]   pos_b, pos1, adv_pos;
   logic [POSITION_BITS-1:0] col_b, col1, col2, adv_line, adv_col;
   logic                     extend, flush_on, single;
   logic [KIND_BITS-1:0]     flush_kind, ident_kind;
   logic [KW_COUNT-1:0]      kw_hit;
   bundle_type               bundle;

   function automatic logic [OFFSET_BITS-1:0] off_add(input logic [OFFSET_BITS-1:0] v,
                                                      input logic [1:0] inc);
      logic [OFFSET_BITS:0] sum;
      sum = {1'b0, v} + {{(OFFSET_BITS - 1){1'b0}}, inc};
      off_add = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
   endfunction

   function automatic logic [POSITION_BITS-1:0] pos_add(input logic [POSITION_BITS-1:0] v,
                                                        input logic [1:0] inc);
      logic [POSITION_BITS:0] sum;
      sum = {1'b0, v} + {{(POSITION_BITS - 1){1'b0}}, inc};
      pos_add = sum[POSITION_BITS] ? '1 : sum[POSITION_BITS-1:0];
   endfunction

   function automatic logic [OFFSET_OUT_BITS-1:0] off_out(input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+OFFSET_OUT_BITS-1:0] ext;
      ext = {{OFFSET_OUT_BITS{1'b0}}, v};
      off_out = ext[OFFSET_OUT_BITS-1:0];
   endfunction

   function automatic logic [POS_OUT_BITS-1:0] pos_out(input logic [POSITION_BITS-1:0] v);
      logic [POSITION_BITS+POS_OUT_BITS-1:0] ext;
      ext = {{POS_OUT_BITS{1'b0}}, v};
      pos_out = ext[POS_OUT_BITS-1:0];
   endfunction

   function automatic token_type make_token(input logic [KIND_BITS-1:0] kind,
                                            input logic [OFFSET_BITS-1:0] off,
                                            input logic [LENGTH_BITS-1:0] len,
                                            input logic [POSITION_BITS-1:0] sl,
                                            input logic [POSITION_BITS-1:0] sc,
                                            input logic [POSITION_BITS-1:0] el,
                                            input logic [POSITION_BITS-1:0] ec);
      token_type t;
      t.kind         = kind;
      t.start_offset = off_out(off);
      t.token_length = len;
      t.start_line   = pos_out(sl);
      t.start_column = pos_out(sc);
      t.end_line     = pos_out(el);
      t.end_column   = pos_out(ec);
      make_token = t;
   endfunction

   assign req_channel.ready = !status.full;
   assign accept   = req_channel.valid && req_channel.ready;
   assign raw_byte = req_channel.data_byte;
   assign drop     = cr_ff && (raw_byte == CHAR_LF);
   assign byte_norm = (raw_byte == CHAR_CR) ? CHAR_LF : raw_byte;

   // byte classes
   always_comb begin
      is_ws    = (byte_norm == CHAR_LF) || (byte_norm == CHAR_TAB) || (byte_norm == CHAR_SPACE);
      is_digit = (byte_norm >= CHAR_ZERO) && (byte_norm <= CHAR_NINE);
      is_alpha = ((byte_norm >= CHAR_UPPER_A) && (byte_norm <= CHAR_UPPER_Z)) ||
                 ((byte_norm >= CHAR_LOWER_A) && (byte_norm <= CHAR_LOWER_Z)) ||
                 (byte_norm == CHAR_UNDERSCORE);
      op_valid = 1'b1;
      unique case (byte_norm)
         CHAR_PLUS:   op_kind = KIND_ADD;
         CHAR_LT:     op_kind = KIND_LT;
         CHAR_GT:     op_kind = KIND_GT;
         CHAR_MINUS:  op_kind = KIND_SUB;
         CHAR_STAR:   op_kind = KIND_MUL;
         CHAR_SLASH:  op_kind = KIND_DIV;
         CHAR_LPAREN: op_kind = KIND_LPAREN;
         CHAR_RPAREN: op_kind = KIND_RPAREN;
         default: begin
            op_kind  = KIND_ERROR;
            op_valid = 1'b0;
         end
      endcase
   end

   // keyword match on the held identifier prefix
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_hit[k] = (pend_len_ff == LENGTH_BITS'(KW_LEN[k])) && (KW_LEN[k] <= KEYWORD_MAX_LEN);
         for (int i = 0; i < KW_MAX_CHARS; i++) begin
            if ((i < KW_LEN[k]) && (i < KEYWORD_MAX_LEN) && (prefix_ff[i] != KW_TEXT[k][i])) begin
               kw_hit[k] = 1'b0;
            end
         end
      end
      ident_kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (kw_hit[k]) begin
            ident_kind = KIND_KW_BASE + KIND_BITS'(k);
         end
      end
   end

   // how many held prologue bytes are replayed, and whether the byte goes on
   always_comb begin
      rep_n     = 2'd0;
      do_normal = 1'b0;
      norm_mode = MODE_IDLE;
      if (req_channel.end_of_input) begin
         norm_mode = mode_ff;
         if ((mode_ff == MODE_BOM1) || (mode_ff == MODE_HASH)) begin
            rep_n = 2'd1;
         end else if (mode_ff == MODE_BOM2) begin
            rep_n = 2'd2;
         end
      end else if (!drop) begin
         unique case (mode_ff)
            MODE_BOM0: begin
               do_normal = (byte_norm != CHAR_BOM0) && (byte_norm != CHAR_HASH);
            end
            MODE_LINE_START: begin
               do_normal = (byte_norm != CHAR_HASH);
            end
            MODE_BOM1: begin
               if (byte_norm != CHAR_BOM1) begin
                  rep_n     = 2'd1;
                  do_normal = 1'b1;
               end
            end
            MODE_BOM2: begin
               if (byte_norm != CHAR_BOM2) begin
                  rep_n     = 2'd2;
                  do_normal = 1'b1;
               end
            end
            MODE_HASH: begin
               if (byte_norm != CHAR_BANG) begin
                  rep_n     = 2'd1;
                  do_normal = 1'b1;
               end
            end
            MODE_SKIP: begin
               do_normal = 1'b0;
            end
            MODE_IDLE, MODE_WS, MODE_INT, MODE_IDENT: begin
               do_normal = 1'b1;
               norm_mode = mode_ff;
            end
            default: begin
               do_normal = 1'b0;
            end
         endcase
      end
   end

   // positions after replay and after the byte itself
   always_comb begin
      pos1  = off_add(pos_ff, 2'd1);
      col1  = pos_add(col_ff, 2'd1);
      col2  = pos_add(col_ff, 2'd2);
      pos_b = off_add(pos_ff, rep_n);
      col_b = pos_add(col_ff, rep_n);
      adv_pos = off_add(pos_b, 2'd1);
      if (byte_norm == CHAR_LF) begin
         adv_line = pos_add(line_ff, 2'd1);
         adv_col  = '0;
      end else begin
         adv_line = line_ff;
         adv_col  = pos_add(col_b, 2'd1);
      end
      extend = ((norm_mode == MODE_WS) && is_ws) ||
               ((norm_mode == MODE_INT) && is_digit) ||
               ((norm_mode == MODE_IDENT) && (is_alpha || is_digit));
      flush_on = (norm_mode == MODE_INT) || (norm_mode == MODE_IDENT) ||
                 ((norm_mode == MODE_WS) && emit_ws_ff);
      if (norm_mode == MODE_WS) begin
         flush_kind = KIND_SPACE;
      end else if (norm_mode == MODE_INT) begin
         flush_kind = KIND_INT;
      end else begin
         flush_kind = ident_kind;
      end
      single = op_valid || !(is_ws || is_digit || is_alpha);
   end

   // next state and token bundle
   always_comb begin
      mode_in      = mode_ff;
      cr_in        = cr_ff;
      pos_in       = pos_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      pend_off_in  = pend_off_ff;
      pend_line_in = pend_line_ff;
      pend_col_in  = pend_col_ff;
      pend_len_in  = pend_len_ff;
      prefix_in    = prefix_ff;
      bundle       = '0;

      // replayed prologue bytes are error tokens on the current line
      bundle.tokens[SLOT_REPLAY0] = make_token(KIND_ERROR, pos_ff, LENGTH_BITS'(1),
                                               line_ff, col_ff, line_ff, col1);
      bundle.tokens[SLOT_REPLAY1] = make_token(KIND_ERROR, pos1, LENGTH_BITS'(1),
                                               line_ff, col1, line_ff, col2);
      bundle.tokens[SLOT_FLUSH]   = make_token(flush_kind, pend_off_ff, pend_len_ff,
                                               pend_line_ff, pend_col_ff, line_ff, col_b);
      bundle.valid[SLOT_REPLAY0]  = accept && (rep_n != 2'd0);
      bundle.valid[SLOT_REPLAY1]  = accept && (rep_n == 2'd2);

      if (req_channel.end_of_input) begin
         bundle.tokens[SLOT_LAST] = make_token(KIND_EOF, pos_b, '0, line_ff, col_b, line_ff, col_b);
      end else begin
         bundle.tokens[SLOT_LAST] = make_token(op_kind, pos_b, LENGTH_BITS'(1),
                                               line_ff, col_b, adv_line, adv_col);
      end

      if (accept) begin
         if (req_channel.end_of_input) begin
            bundle.valid[SLOT_FLUSH] = flush_on;
            bundle.valid[SLOT_LAST]  = 1'b1;
            mode_in      = MODE_BOM0;
            cr_in        = 1'b0;
            pos_in       = '0;
            line_in      = '0;
            col_in       = '0;
            pend_off_in  = '0;
            pend_line_in = '0;
            pend_col_in  = '0;
            pend_len_in  = '0;
         end else if (drop) begin
            cr_in = 1'b0;
         end else begin
            cr_in = (raw_byte == CHAR_CR);
            unique case (mode_ff)
               MODE_BOM0: begin
                  if (byte_norm == CHAR_BOM0) begin
                     mode_in = MODE_BOM1;
                  end else if (byte_norm == CHAR_HASH) begin
                     mode_in = MODE_HASH;
                  end
               end
               MODE_LINE_START: begin
                  if (byte_norm == CHAR_HASH) begin
                     mode_in = MODE_HASH;
                  end
               end
               MODE_BOM1: begin
                  if (byte_norm == CHAR_BOM1) begin
                     mode_in = MODE_BOM2;
                  end
               end
               MODE_BOM2: begin
                  // the mark counts in offsets only
                  if (byte_norm == CHAR_BOM2) begin
                     pos_in  = off_add(pos_ff, 2'd3);
                     mode_in = MODE_LINE_START;
                  end
               end
               MODE_HASH: begin
                  if (byte_norm == CHAR_BANG) begin
                     pos_in  = off_add(pos_ff, 2'd2);
                     col_in  = col2;
                     mode_in = MODE_SKIP;
                  end
               end
               MODE_SKIP: begin
                  pos_in  = adv_pos;
                  line_in = adv_line;
                  col_in  = adv_col;
                  if (byte_norm == CHAR_LF) begin
                     mode_in = MODE_LINE_START;
                  end
               end
               MODE_IDLE, MODE_WS, MODE_INT, MODE_IDENT: begin
                  mode_in = mode_ff;
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase

            if (do_normal) begin
               pos_in  = adv_pos;
               line_in = adv_line;
               col_in  = adv_col;
               if (extend) begin
                  mode_in = norm_mode;
                  if ((norm_mode == MODE_IDENT) &&
                      (pend_len_ff < LENGTH_BITS'(KEYWORD_MAX_LEN))) begin
                     prefix_in[pend_len_ff[PREFIX_IDX_BITS-1:0]] = byte_norm;
                  end
                  if (pend_len_ff != '1) begin
                     pend_len_in = pend_len_ff + LENGTH_BITS'(1);
                  end
               end else begin
                  bundle.valid[SLOT_FLUSH] = flush_on;
                  if (single) begin
                     bundle.valid[SLOT_LAST] = 1'b1;
                     mode_in = MODE_IDLE;
                  end else begin
                     pend_off_in  = pos_b;
                     pend_line_in = line_ff;
                     pend_col_in  = col_b;
                     pend_len_in  = LENGTH_BITS'(1);
                     prefix_in[0] = byte_norm;
                     if (is_ws) begin
                        mode_in = MODE_WS;
                     end else if (is_digit) begin
                        mode_in = MODE_INT;
                     end else begin
                        mode_in = MODE_IDENT;
                     end
                  end
               end
            end
         end
      end
   end

   assign push      = accept && (bundle.valid != '0);
   assign push_data = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BOM0;
         emit_ws_ff   <= 1'b0;
         cr_ff        <= 1'b0;
         pos_ff       <= '0;
         line_ff      <= '0;
         col_ff       <= '0;
         pend_off_ff  <= '0;
         pend_line_ff <= '0;
         pend_col_ff  <= '0;
         pend_len_ff  <= '0;
      end else begin
         mode_ff      <= mode_in;
         cr_ff        <= cr_in;
         pos_ff       <= pos_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         pend_off_ff  <= pend_off_in;
         pend_line_ff <= pend_line_in;
         pend_col_ff  <= pend_col_in;
         pend_len_ff  <= pend_len_in;
         if (csr_write_enable) begin
            emit_ws_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
   end

endmodule

### hdl/stl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_queue
// Short first-in first-out queue of token bundles between front and back.
// ----------------------------------------------------------------------------
module stl_queue import stl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_data,
   input  logic             pop,
   output bundle_type       pop_data,
   output queue_status_type status
);

   // depth is a power of two, so the pointers wrap on their own
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   bundle_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign status.full  = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + PTR_BITS'(1) : wr_ff;
      rd_in    = pop ? rd_ff + PTR_BITS'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

### hdl/stl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back
// Token back end: holds one bundle and hands its tokens out one transfer at a
// time, marking the final token of each source byte.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       pop_data,
   input  queue_status_type status,
   output logic             pop,
   stl_rsp_if.source        rsp_channel
);

   token_type [TOKEN_SLOTS-1:0] tokens_ff;
   logic [TOKEN_SLOTS-1:0]      mask_ff, mask_in;
   logic [TOKEN_SLOTS-1:0]      sel, rest;
   token_type                   cur;
   logic                        xfer;

   always_comb begin
      sel  = mask_ff & (~mask_ff + TOKEN_SLOTS'(1));
      rest = mask_ff & ~sel;
      cur  = tokens_ff[0];
      for (int i = TOKEN_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur = tokens_ff[i];
         end
      end
   end

   assign rsp_channel.valid        = (mask_ff != '0);
   assign rsp_channel.token_kind   = cur.kind;
   assign rsp_channel.start_offset = cur.start_offset;
   assign rsp_channel.token_length = cur.token_length;
   assign rsp_channel.start_line   = cur.start_line;
   assign rsp_channel.start_column = cur.start_column;
   assign rsp_channel.end_line     = cur.end_line;
   assign rsp_channel.end_column   = cur.end_column;
   assign rsp_channel.last_of_run  = (rest == '0);

   assign xfer = rsp_channel.valid && rsp_channel.ready;
   // load the next bundle as soon as the last token of this one goes
   assign pop  = ((mask_ff == '0) || (xfer && (rest == '0))) && !status.empty;

   always_comb begin
      mask_in = mask_ff;
      if (pop) begin
         mask_in = pop_data.valid;
      end else if (xfer) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tokens_ff <= pop_data.tokens;
      end
   end

endmodule

### verif/source_token_lexer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer_checker
// Watches the byte and token channels of the lexer and keeps its own scanner
// in step with every accepted byte. It queues the tokens each byte should
// produce and compares every token transfer field by field with the oldest
// one queued. It reports how many tokens are still owed and how many errors
// were seen.
// ----------------------------------------------------------------------------
module source_token_lexer_checker import stl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   stl_req_if          req_mon,
   stl_rsp_if          rsp_mon,
   output int unsigned error_count,
   output int unsigned tokens_waiting
);

   localparam int PREFIX_DEPTH        = 6;
   localparam int PREFIX_IDX_BITS     = $clog2(PREFIX_DEPTH);
   localparam int MAX_TOKENS_PER_ITEM = 4;

   localparam logic [OFFSET_OUT_BITS-1:0] OFFSET_MAX = {OFFSET_OUT_BITS{1'b1}};
   localparam logic [POS_OUT_BITS-1:0]    POS_MAX    = {POS_OUT_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0]     LEN_MAX    = {LENGTH_BITS{1'b1}};

   localparam logic [KIND_BITS-1:0] KIND_RETURN = KIND_KW_BASE;
   localparam logic [KIND_BITS-1:0] KIND_IF     = KIND_KW_BASE + 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_FN     = KIND_KW_BASE + 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_END    = KIND_KW_BASE + 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_WHILE  = KIND_KW_BASE + 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_BUFFER = KIND_KW_BASE + 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_VAR    = KIND_KW_BASE + 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_AUTO   = KIND_KW_BASE + 5'd7;

   typedef enum logic [9:0] {
      SCAN_BOM0       = 10'b0000000001,
      SCAN_BOM1       = 10'b0000000010,
      SCAN_BOM2       = 10'b0000000100,
      SCAN_LINE_START = 10'b0000001000,
      SCAN_HASH       = 10'b0000010000,
      SCAN_SKIP       = 10'b0000100000,
      SCAN_IDLE       = 10'b0001000000,
      SCAN_SPACE      = 10'b0010000000,
      SCAN_INT        = 10'b0100000000,
      SCAN_WORD       = 10'b1000000000
   } scan_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]       kind;
      logic [OFFSET_OUT_BITS-1:0] offset;
      logic [LENGTH_BITS-1:0]     length;
      logic [POS_OUT_BITS-1:0]    start_line;
      logic [POS_OUT_BITS-1:0]    start_column;
      logic [POS_OUT_BITS-1:0]    end_line;
      logic [POS_OUT_BITS-1:0]    end_column;
      logic                       last;
   } lexed_token_type;

   lexed_token_type expected_tokens [$];
   lexed_token_type step_tokens [$];

   scan_state_type             scan_state;
   logic [7:0]                 held_bytes [2];
   int unsigned                held_count;
   logic                       cr_pending;
   logic [OFFSET_OUT_BITS-1:0] byte_offset;
   logic [POS_OUT_BITS-1:0]    line_no;
   logic [POS_OUT_BITS-1:0]    column_no;
   logic [OFFSET_OUT_BITS-1:0] run_offset;
   logic [POS_OUT_BITS-1:0]    run_line;
   logic [POS_OUT_BITS-1:0]    run_column;
   logic [LENGTH_BITS-1:0]     run_length;
   logic [7:0]                 run_text [PREFIX_DEPTH];
   logic                       ws_enable;

   function automatic void lexer_clear();
      scan_state = SCAN_BOM0;
      held_bytes[0] = '0;
      held_bytes[1] = '0;
      held_count = 0;
      cr_pending = 1'b0;
      byte_offset = '0;
      line_no = '0;
      column_no = '0;
      run_offset = '0;
      run_line = '0;
      run_column = '0;
      run_length = '0;
      for (int i = 0; i < PREFIX_DEPTH; i++) run_text[i] = '0;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return b == CHAR_LF || b == CHAR_TAB || b == CHAR_SPACE;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
             (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) || b == CHAR_UNDERSCORE;
   endfunction

   // the eof code doubles as "not an operator"
   function automatic logic [KIND_BITS-1:0] operator_kind(input logic [7:0] b);
      unique case (b)
         CHAR_PLUS:   return KIND_ADD;
         CHAR_LT:     return KIND_LT;
         CHAR_GT:     return KIND_GT;
         CHAR_MINUS:  return KIND_SUB;
         CHAR_STAR:   return KIND_MUL;
         CHAR_SLASH:  return KIND_DIV;
         CHAR_LPAREN: return KIND_LPAREN;
         CHAR_RPAREN: return KIND_RPAREN;
         default:     return KIND_EOF;
      endcase
   endfunction

   function automatic void pos_advance(input logic [7:0] b);
      if (byte_offset != OFFSET_MAX) byte_offset = byte_offset + 1'b1;
      if (b == CHAR_LF) begin
         if (line_no != POS_MAX) line_no = line_no + 1'b1;
         column_no = '0;
      end else if (column_no != POS_MAX) begin
         column_no = column_no + 1'b1;
      end
   endfunction

   function automatic void push_token(input logic [KIND_BITS-1:0] kind,
                                      input logic [OFFSET_OUT_BITS-1:0] offset,
                                      input logic [LENGTH_BITS-1:0] length,
                                      input logic [POS_OUT_BITS-1:0] first_line,
                                      input logic [POS_OUT_BITS-1:0] first_column);
      lexed_token_type tok;
      if (step_tokens.size() >= MAX_TOKENS_PER_ITEM) return;
      tok.kind = kind;
      tok.offset = offset;
      tok.length = length;
      tok.start_line = first_line;
      tok.start_column = first_column;
      tok.end_line = line_no;
      tok.end_column = column_no;
      tok.last = 1'b0;
      step_tokens.push_back(tok);
   endfunction

   // word held right-justified so short keywords compare against short literals
   function automatic logic [KIND_BITS-1:0] keyword_or_ident();
      logic [8*PREFIX_DEPTH-1:0] word;
      word = '0;
      if (run_length > PREFIX_DEPTH) return KIND_IDENT;
      for (int i = 0; i < run_length; i++) word = {word[8*PREFIX_DEPTH-9:0], run_text[i]};
      if (run_length == 6 && word == "return") return KIND_RETURN;
      if (run_length == 2 && word == "if")     return KIND_IF;
      if (run_length == 2 && word == "fn")     return KIND_FN;
      if (run_length == 3 && word == "end")    return KIND_END;
      if (run_length == 5 && word == "while")  return KIND_WHILE;
      if (run_length == 6 && word == "buffer") return KIND_BUFFER;
      if (run_length == 3 && word == "var")    return KIND_VAR;
      if (run_length == 4 && word == "auto")   return KIND_AUTO;
      return KIND_IDENT;
   endfunction

   // the enable is looked at only here, when a run closes
   function automatic void close_run();
      logic [KIND_BITS-1:0] kind;
      unique case (scan_state)
         SCAN_SPACE: begin
            if (!ws_enable) begin
               scan_state = SCAN_IDLE;
               return;
            end
            kind = KIND_SPACE;
         end
         SCAN_INT:  kind = KIND_INT;
         SCAN_WORD: kind = keyword_or_ident();
         default:   return;
      endcase
      push_token(kind, run_offset, run_length, run_line, run_column);
      scan_state = SCAN_IDLE;
   endfunction

   function automatic void scan_plain(input logic [7:0] b);
      logic                       grow;
      logic [KIND_BITS-1:0]       op;
      logic [OFFSET_OUT_BITS-1:0] first_offset;
      logic [POS_OUT_BITS-1:0]    first_line;
      logic [POS_OUT_BITS-1:0]    first_column;
      grow = (scan_state == SCAN_SPACE && is_blank(b)) ||
             (scan_state == SCAN_INT && is_digit(b)) ||
             (scan_state == SCAN_WORD && (is_letter(b) || is_digit(b)));
      if (grow) begin
         if (scan_state == SCAN_WORD && run_length < PREFIX_DEPTH)
            run_text[run_length[PREFIX_IDX_BITS-1:0]] = b;
         if (run_length != LEN_MAX) run_length = run_length + 1'b1;
         pos_advance(b);
         return;
      end
      close_run();
      scan_state = SCAN_IDLE;
      op = operator_kind(b);
      if (op != KIND_EOF || !(is_blank(b) || is_digit(b) || is_letter(b))) begin
         first_offset = byte_offset;
         first_line = line_no;
         first_column = column_no;
         pos_advance(b);
         if (op != KIND_EOF)
            push_token(op, first_offset, LENGTH_BITS'(1), first_line, first_column);
         else
            push_token(KIND_ERROR, first_offset, LENGTH_BITS'(1), first_line, first_column);
         return;
      end
      run_offset = byte_offset;
      run_line = line_no;
      run_column = column_no;
      run_length = LENGTH_BITS'(1);
      run_text[0] = b;
      if (is_blank(b)) scan_state = SCAN_SPACE;
      else if (is_digit(b)) scan_state = SCAN_INT;
      else scan_state = SCAN_WORD;
      pos_advance(b);
   endfunction

   function automatic void replay_prefix();
      int unsigned n;
      n = held_count;
      held_count = 0;
      scan_state = SCAN_IDLE;
      for (int i = 0; i < n && i < 2; i++) scan_plain(held_bytes[i]);
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      unique case (scan_state)
         SCAN_BOM0: begin
            if (b == CHAR_BOM0) begin
               held_bytes[0] = b;
               held_count = 1;
               scan_state = SCAN_BOM1;
            end else if (b == CHAR_HASH) begin
               // no mark, so the first byte is also the start of a line
               held_bytes[0] = b;
               held_count = 1;
               scan_state = SCAN_HASH;
            end else begin
               scan_state = SCAN_IDLE;
               scan_plain(b);
            end
         end
         SCAN_LINE_START: begin
            if (b == CHAR_HASH) begin
               held_bytes[0] = b;
               held_count = 1;
               scan_state = SCAN_HASH;
            end else begin
               scan_state = SCAN_IDLE;
               scan_plain(b);
            end
         end
         SCAN_BOM1: begin
            if (b == CHAR_BOM1) begin
               held_bytes[1] = b;
               held_count = 2;
               scan_state = SCAN_BOM2;
            end else begin
               replay_prefix();
               scan_plain(b);
            end
         end
         SCAN_BOM2: begin
            if (b == CHAR_BOM2) begin
               // the mark counts in offsets but not in columns
               held_count = 0;
               if (byte_offset > OFFSET_MAX - OFFSET_OUT_BITS'(3)) byte_offset = OFFSET_MAX;
               else byte_offset = byte_offset + OFFSET_OUT_BITS'(3);
               scan_state = SCAN_LINE_START;
            end else begin
               replay_prefix();
               scan_plain(b);
            end
         end
         SCAN_HASH: begin
            if (b == CHAR_BANG) begin
               held_count = 0;
               pos_advance(CHAR_HASH);
               pos_advance(CHAR_BANG);
               scan_state = SCAN_SKIP;
            end else begin
               replay_prefix();
               scan_plain(b);
            end
         end
         SCAN_SKIP: begin
            pos_advance(b);
            if (b == CHAR_LF) scan_state = SCAN_LINE_START;
         end
         default: scan_plain(b);
      endcase
   endfunction

   function automatic void predict_step(input logic [7:0] raw, input logic marker);
      logic [7:0]      b;
      lexed_token_type tok;
      step_tokens.delete();
      b = raw;
      if (marker) begin
         if (scan_state == SCAN_BOM1 || scan_state == SCAN_BOM2 || scan_state == SCAN_HASH)
            replay_prefix();
         close_run();
         push_token(KIND_EOF, byte_offset, '0, line_no, column_no);
         lexer_clear();
      end else if (cr_pending && b == CHAR_LF) begin
         // second half of a crlf pair
         cr_pending = 1'b0;
      end else begin
         cr_pending = (b == CHAR_CR);
         if (b == CHAR_CR) b = CHAR_LF;
         scan_byte(b);
      end
      for (int i = 0; i < step_tokens.size(); i++) begin
         tok = step_tokens[i];
         tok.last = (i == step_tokens.size() - 1);
         expected_tokens.push_back(tok);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_token();
      lexed_token_type want;
      if (expected_tokens.size() == 0) begin
         $error("token with none expected: token_kind %0d start_offset %0d",
                rsp_mon.token_kind, rsp_mon.start_offset);
         error_count++;
         return;
      end
      want = expected_tokens.pop_front();
      check_field("token_kind", want.kind, rsp_mon.token_kind);
      check_field("start_offset", want.offset, rsp_mon.start_offset);
      check_field("token_length", want.length, rsp_mon.token_length);
      check_field("start_line", want.start_line, rsp_mon.start_line);
      check_field("start_column", want.start_column, rsp_mon.start_column);
      check_field("end_line", want.end_line, rsp_mon.end_line);
      check_field("end_column", want.end_column, rsp_mon.end_column);
      check_field("last_of_run", want.last, rsp_mon.last_of_run);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         lexer_clear();
         ws_enable = 1'b0;
         expected_tokens.delete();
      end else begin
         if (csr_write_enable) ws_enable = csr_write_data;
         if (req_mon.valid && req_mon.ready)
            predict_step(req_mon.data_byte, req_mon.end_of_input);
         if (rsp_mon.valid && rsp_mon.ready) check_token();
      end
      tokens_waiting = expected_tokens.size();
   end

endmodule

### verif/tb_source_token_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_token_lexer_top
// Feeds the lexer with short source files: a directed set covering the file
// prologue, line endings, keywords, stray bytes and the whitespace enable,
// then random files built mostly from well-formed lexemes with some noise.
// Both channels idle at random; the token side is held off for a long
// stretch at files 2 and 9. A side checker predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_source_token_lexer_top import stl_pkg::*; ();

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int ITEM_TARGET     = 310;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   // worst quiet stretch is the long hold-off plus a long gap; several times over
   localparam int WATCHDOG_LIMIT  = 3000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_write_data;
   int unsigned error_count;
   int unsigned tokens_waiting;
   int unsigned items_sent = 0;
   int unsigned stall_cycles = 0;
   bit          steady = 1'b0;
   bit          hold_off_request = 1'b0;

   string keyword_words [8] = '{"return", "if", "fn", "end", "while", "buffer", "var", "auto"};
   logic [7:0] operator_chars [8] = '{CHAR_PLUS, CHAR_LT, CHAR_GT, CHAR_MINUS,
                                      CHAR_STAR, CHAR_SLASH, CHAR_LPAREN, CHAR_RPAREN};

   stl_req_if req_if ();
   stl_rsp_if rsp_if ();

   source_token_lexer_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if)
   );

   source_token_lexer_checker token_monitor (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .error_count      (error_count),
      .tokens_waiting   (tokens_waiting)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_source_token_lexer_top: errors");
            $finish;
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(99, 0);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic logic [7:0] word_char(input bit allow_digit);
      int unsigned r;
      r = allow_digit ? $urandom_range(62, 0) : $urandom_range(52, 0);
      if (r < 26) return CHAR_LOWER_A + r[7:0];
      if (r < 52) return CHAR_UPPER_A + r[7:0] - 8'd26;
      if (r == 52) return CHAR_UNDERSCORE;
      return CHAR_ZERO + r[7:0] - 8'd53;
   endfunction

   function automatic logic [7:0] digit_char();
      int unsigned r;
      r = $urandom_range(9, 0);
      return CHAR_ZERO + r[7:0];
   endfunction

   initial begin : receiver
      int unsigned gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            gap = idle_gap();
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // called at a falling edge; valid stays high when no gap follows
   task automatic send_item(input logic [7:0] value, input logic marker);
      int unsigned gap;
      req_if.valid <= 1'b1;
      req_if.data_byte <= value;
      req_if.end_of_input <= marker;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         req_if.data_byte <= 8'($urandom_range(255, 0));
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_marker();
      send_item(8'($urandom_range(255, 0)), 1'b1);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
   endtask

   task automatic send_line_break();
      int unsigned pick;
      pick = $urandom_range(2, 0);
      if (pick == 0) begin
         send_item(CHAR_LF, 1'b0);
      end else begin
         send_item(CHAR_CR, 1'b0);
         if (pick == 2) send_item(CHAR_LF, 1'b0);
      end
   endtask

   task automatic send_blank();
      int unsigned pick;
      pick = $urandom_range(4, 0);
      if (pick == 0) send_item(CHAR_SPACE, 1'b0);
      else if (pick == 1) send_item(CHAR_TAB, 1'b0);
      else send_line_break();
   endtask

   task automatic send_lexeme();
      int unsigned pick;
      int unsigned n;
      string       word;
      pick = $urandom_range(99, 0);
      if (pick < 20) begin
         send_text(keyword_words[$urandom_range(7, 0)]);
      end else if (pick < 32) begin
         // near misses of a keyword
         word = keyword_words[$urandom_range(7, 0)];
         if ($urandom_range(1, 0)) begin
            send_text(word.substr(0, word.len() - 2));
         end else begin
            send_text(word);
            send_item(word_char(1'b1), 1'b0);
         end
      end else if (pick < 47) begin
         n = $urandom_range(8, 1);
         send_item(word_char(1'b0), 1'b0);
         repeat (n - 1) send_item(word_char(1'b1), 1'b0);
      end else if (pick < 60) begin
         repeat ($urandom_range(5, 1)) send_item(digit_char(), 1'b0);
      end else if (pick < 80) begin
         repeat ($urandom_range(3, 1)) send_blank();
      end else if (pick < 95) begin
         send_item(operator_chars[$urandom_range(7, 0)], 1'b0);
      end else begin
         send_item(8'($urandom_range(255, 0)), 1'b0);
      end
   endtask

   task automatic send_random_file();
      int unsigned pick;
      int unsigned count;
      pick = $urandom_range(9, 0);
      if (pick < 2) begin
         send_item(CHAR_BOM0, 1'b0);
         send_item(CHAR_BOM1, 1'b0);
         send_item(CHAR_BOM2, 1'b0);
      end else if (pick == 2) begin
         // mark cut short
         send_item(CHAR_BOM0, 1'b0);
         if ($urandom_range(1, 0)) send_item(CHAR_BOM1, 1'b0);
      end else if (pick < 5) begin
         send_item(CHAR_HASH, 1'b0);
         if ($urandom_range(3, 0) != 0) begin
            send_item(CHAR_BANG, 1'b0);
            repeat ($urandom_range(4, 0)) send_item(word_char(1'b1), 1'b0);
            if ($urandom_range(4, 0) == 0) begin
               send_marker();
               return;
            end
            send_line_break();
         end
      end
      count = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(14, 3);
      repeat (count) send_lexeme();
      send_marker();
   endtask

   // every owed token delivered, then a settling wait for bytes that give none
   task automatic wait_for_quiet();
      if (req_if.valid) req_if.valid <= 1'b0;
      while (tokens_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_whitespace_enable(input logic value);
      wait_for_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned file_no;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.end_of_input = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shebang line closed by crlf, keyword, skipped blank, int, operator, nul
      write_whitespace_enable(1'b0);
      send_text("#!");
      send_item(CHAR_CR, 1'b0);
      send_item(CHAR_LF, 1'b0);
      send_text("fn 7*");
      send_item(8'h00, 1'b0);
      send_marker();

      // broken mark replayed as ordinary bytes, then the top byte value
      write_whitespace_enable(1'b1);
      send_item(CHAR_BOM0, 1'b0);
      send_item(CHAR_BOM1, 1'b0);
      send_item(8'hFF, 1'b0);
      send_marker();

      // full mark, blank run with a lone cr, enable dropped before the run closes
      send_item(CHAR_BOM0, 1'b0);
      send_item(CHAR_BOM1, 1'b0);
      send_item(CHAR_BOM2, 1'b0);
      send_item(CHAR_TAB, 1'b0);
      send_item(CHAR_CR, 1'b0);
      write_whitespace_enable(1'b0);
      send_text("_9");
      send_marker();

      // shebang cut off by end of file
      send_text("#!q");
      send_marker();

      for (file_no = 0; items_sent < ITEM_TARGET; file_no++) begin
         if (file_no % 3 == 0) write_whitespace_enable(1'($urandom_range(1, 0)));
         steady = (file_no % 5 == 4);
         if (file_no == 2 || file_no == 9) begin
            // token side stalls while bytes keep coming
            steady = 1'b1;
            hold_off_request = 1'b1;
         end
         send_random_file();
      end
      steady = 1'b0;

      wait_for_quiet();
      if (error_count == 0) $display("tb_source_token_lexer_top: clean");
      else $display("tb_source_token_lexer_top: errors");
      $finish;
   end

endmodule
